[sv/vlbr_pkg.sv]
// shared types and constants of the voxel layer box rasterizer
package vlbr_pkg;

  // linear cell index width, as carried by read items and draw addressing
  localparam int unsigned IDX_W = 12;
  // cells reachable through a 12-bit index
  localparam int unsigned IDX_SPAN = 1 << IDX_W;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned SIDE_W = 6;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BED_LAST_COLUMN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BED_LAST_ROW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COLUMN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LAYER   = 3'd4;

  // reset value of the bed last column and bed last row registers
  localparam logic [SIDE_W-1:0] BED_LAST_RST = 6'd63;

  typedef struct packed {
    logic [SIDE_W-1:0]  bed_last_column;
    logic [SIDE_W-1:0]  bed_last_row;
    logic [COORD_W-1:0] origin_column;
    logic [COORD_W-1:0] origin_row;
    logic [COORD_W-1:0] current_layer;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] box_column;
    logic [COORD_W-1:0] box_row;
    logic [COORD_W-1:0] box_layer;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [COORD_W-1:0] box_depth;
    logic [CODE_W-1:0]  material;
    logic [IDX_W-1:0]   cell_address;
  } item_t;

  typedef struct packed {
    logic              status;
    logic [CODE_W-1:0] cell_material;
  } res_t;

endpackage

[sv/vlbr_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module vlbr_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/vlbr_ctrl.sv]
// item sequencer: clearing sweep, box placement and fit check, row fill, cell read
module vlbr_ctrl #(
  parameter int unsigned RAM_DEPTH = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vlbr_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vlbr_pkg::item_t                 item_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output vlbr_pkg::res_t                  res_o,
  output logic                            mem_we_o,
  output logic [ADDR_W-1:0]               mem_waddr_o,
  output logic [vlbr_pkg::CODE_W-1:0]     mem_wdata_o,
  output logic [ADDR_W-1:0]               mem_raddr_o,
  input  logic [vlbr_pkg::CODE_W-1:0]     mem_rdata_i
);
  import vlbr_pkg::*;

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(RAM_DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(RAM_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_CHECK,
    ST_FILL,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                clr_item_q;
  item_t               item_q;
  logic [COORD_W:0]    col_q;
  logic [COORD_W:0]    row_q;
  logic [COORD_W:0]    top_q;
  logic [SIDE_W-1:0]   c_q;
  logic [SIDE_W-1:0]   r_q;
  logic [SIDE_W-1:0]   c_first_q;
  logic [SIDE_W-1:0]   c_last_q;
  logic [SIDE_W-1:0]   r_last_q;
  logic [IDX_W-1:0]    base_q;
  res_t                res_q;

  logic [COORD_W+1:0]  col_end;
  logic [COORD_W+1:0]  row_end;
  logic                empty_box;
  logic                fits;
  logic                in_layer;
  logic [SIDE_W:0]     pitch;
  logic [IDX_W:0]      base_prod;
  logic [IDX_W-1:0]    fill_idx;
  logic                fill_ok;
  logic                read_ok;

  // placement, fit and layer checks
  assign col_end   = (COORD_W+2)'(col_q) + (COORD_W+2)'(item_q.box_width) - 1'b1;
  assign row_end   = (COORD_W+2)'(row_q) + (COORD_W+2)'(item_q.box_height) - 1'b1;
  assign empty_box = (item_q.box_width == '0) || (item_q.box_height == '0);
  assign fits      = (col_end <= (COORD_W+2)'(cfg_i.bed_last_column)) &&
                     (row_end <= (COORD_W+2)'(cfg_i.bed_last_row));
  assign in_layer  = (cfg_i.current_layer >= item_q.box_layer) &&
                     ((COORD_W+1)'(cfg_i.current_layer) < top_q);
  assign pitch     = (SIDE_W+1)'(cfg_i.bed_last_column) + 1'b1;
  assign base_prod = (IDX_W+1)'(row_q[SIDE_W-1:0]) * (IDX_W+1)'(pitch);

  // cell index of the fill position and store bounds
  assign fill_idx = base_q + IDX_W'(c_q);
  assign fill_ok  = {1'b0, fill_idx} < IDX_LIMIT;
  assign read_ok  = {1'b0, item_q.cell_address} < IDX_LIMIT;

  // memory port drive
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = ADDR_W'(fill_idx);
    mem_wdata_o = item_q.material;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_cnt_q;
        mem_wdata_o = '0;
      end
      ST_FILL: begin
        mem_we_o = fill_ok;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  assign mem_raddr_o = ADDR_W'(item_q.cell_address);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // sequencer state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      clr_item_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == CLR_LAST) begin
            clr_cnt_q <= '0;
            res_q     <= '0;
            state_q   <= clr_item_q ? ST_DONE : ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= item_i;
            res_q  <= '0;
            unique case (item_i.kind)
              KIND_CLEAR: begin
                clr_item_q <= 1'b1;
                clr_cnt_q  <= '0;
                state_q    <= ST_CLEAR;
              end
              KIND_DRAW: state_q <= ST_PLACE;
              KIND_READ: state_q <= ST_READ;
              default:   state_q <= ST_DONE;
            endcase
          end
        end
        ST_PLACE: begin
          col_q   <= (COORD_W+1)'(cfg_i.origin_column) + (COORD_W+1)'(item_q.box_column);
          row_q   <= (COORD_W+1)'(cfg_i.origin_row) + (COORD_W+1)'(item_q.box_row);
          top_q   <= (COORD_W+1)'(item_q.box_layer) + (COORD_W+1)'(item_q.box_depth);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          c_q       <= col_q[SIDE_W-1:0];
          c_first_q <= col_q[SIDE_W-1:0];
          r_q       <= row_q[SIDE_W-1:0];
          c_last_q  <= col_end[SIDE_W-1:0];
          r_last_q  <= row_end[SIDE_W-1:0];
          base_q    <= base_prod[IDX_W-1:0];
          priority if (empty_box) begin
            state_q <= ST_DONE;
          end else if (!fits) begin
            res_q.status <= 1'b1;
            state_q      <= ST_DONE;
          end else if (!in_layer) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_FILL;
          end
        end
        ST_FILL: begin
          // one cell per cycle, column by column, then next row
          if (c_q == c_last_q) begin
            c_q <= c_first_q;
            if (r_q == r_last_q) begin
              state_q <= ST_DONE;
            end else begin
              r_q    <= r_q + 1'b1;
              base_q <= base_q + IDX_W'(pitch);
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_RDATA;
        end
        ST_RDATA: begin
          res_q.cell_material <= read_ok ? mem_rdata_i : '0;
          state_q             <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            clr_item_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/voxel_layer_box_rasterizer.sv]
// top level of the voxel layer box rasterizer: configuration, result register, layer store
// Keeps one layer of a print bed as a store of 4-bit material codes, one entry per cell.
// Items arrive on the in channel (in_valid_i / in_ready_o), results leave on the out
// channel (out_valid_o / out_ready_i), one result per item. Configuration registers are
// written through the cfg channel, which is always ready; the user writes them only while no
// item is in progress, which the block does not enforce. Items are worked one at a time out
// of a single layer ram with registered read data:
//   read item   ram read, then the cell code registered into the result
//   draw item   placement and fit check, then one cell a cycle when the box is written
//   clear item  one ram entry zeroed per cycle across the whole store
//   unused kind no ram access, an all-zero result
// The store depth is min(BED_SIDE * BED_SIDE, 4096) entries; after reset the block zeroes it
// with the same sweep, holding in_ready_o low until done; cfg transfers are taken meanwhile.
// The result sits in an output register; while the receiver stalls, the next item is
// taken and worked, and it waits only to hand over its own result.
module voxel_layer_box_rasterizer #(
  parameter int unsigned BED_SIDE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        kind_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_column_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_row_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_layer_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_width_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_height_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      box_depth_i,
  input  logic [vlbr_pkg::CODE_W-1:0]       material_i,
  input  logic [vlbr_pkg::IDX_W-1:0]        cell_address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [vlbr_pkg::CODE_W-1:0]       cell_material_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vlbr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vlbr_pkg::COORD_W-1:0]      cfg_data_i
);
  import vlbr_pkg::*;

  localparam int unsigned CELL_COUNT = BED_SIDE * BED_SIDE;
  localparam int unsigned RAM_DEPTH = (CELL_COUNT < IDX_SPAN) ? CELL_COUNT : IDX_SPAN;
  localparam int unsigned ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  cfg_t               cfg_q;
  item_t              item;
  res_t               res;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;
  logic               status_q;
  logic [CODE_W-1:0]  cell_material_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CODE_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CODE_W-1:0]  mem_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bed_last_column <= BED_LAST_RST;
      cfg_q.bed_last_row    <= BED_LAST_RST;
      cfg_q.origin_column   <= '0;
      cfg_q.origin_row      <= '0;
      cfg_q.current_layer   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BED_LAST_COLUMN: cfg_q.bed_last_column <= cfg_data_i[SIDE_W-1:0];
        REG_BED_LAST_ROW:    cfg_q.bed_last_row    <= cfg_data_i[SIDE_W-1:0];
        REG_ORIGIN_COLUMN:   cfg_q.origin_column   <= cfg_data_i;
        REG_ORIGIN_ROW:      cfg_q.origin_row      <= cfg_data_i;
        REG_CURRENT_LAYER:   cfg_q.current_layer   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input item gathered into one struct
  assign item.kind         = kind_i;
  assign item.box_column   = box_column_i;
  assign item.box_row      = box_row_i;
  assign item.box_layer    = box_layer_i;
  assign item.box_width    = box_width_i;
  assign item.box_height   = box_height_i;
  assign item.box_depth    = box_depth_i;
  assign item.material     = material_i;
  assign item.cell_address = cell_address_i;

  vlbr_ctrl #(
    .RAM_DEPTH(RAM_DEPTH),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  vlbr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (RAM_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_layer_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register, refilled when empty or when its result is transferred
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
      if (res_valid && res_ready) begin
        status_q        <= res.status;
        cell_material_q <= res.cell_material;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign cell_material_o = cell_material_q;

endmodule

[sv/vlbr_checker.sv]
// port-level checker of the voxel layer box rasterizer, bound to the top level
module vlbr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        status_o,
  input logic [vlbr_pkg::CODE_W-1:0] cell_material_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(cell_material_o))
  else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
  else $error("input taken while an item is in progress");

  // a rejected box never carries a cell code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> cell_material_o == '0)
  else $error("error status with nonzero cell code");

  // a new result comes only from an item in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
  else $error("result appeared while idle");

endmodule

bind voxel_layer_box_rasterizer vlbr_checker u_checker (.*);

[bench/voxel_layer_box_rasterizer_test.sv]
// self-checking testbench of the voxel layer box rasterizer: random and directed items
module voxel_layer_box_rasterizer_test;
  import vlbr_pkg::*;

  localparam int unsigned BED_SIDE = 64;
  localparam int unsigned CELL_COUNT = BED_SIDE * BED_SIDE;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 153;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           kind_i = '0;
  logic [COORD_W-1:0]   box_column_i = '0;
  logic [COORD_W-1:0]   box_row_i = '0;
  logic [COORD_W-1:0]   box_layer_i = '0;
  logic [COORD_W-1:0]   box_width_i = '0;
  logic [COORD_W-1:0]   box_height_i = '0;
  logic [COORD_W-1:0]   box_depth_i = '0;
  logic [CODE_W-1:0]    material_i = '0;
  logic [IDX_W-1:0]     cell_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 status_o;
  logic [CODE_W-1:0]    cell_material_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COORD_W-1:0]   cfg_data_i = '0;

  voxel_layer_box_rasterizer #(
    .BED_SIDE(BED_SIDE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .box_column_i   (box_column_i),
    .box_row_i      (box_row_i),
    .box_layer_i    (box_layer_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .box_depth_i    (box_depth_i),
    .material_i     (material_i),
    .cell_address_i (cell_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .cell_material_o(cell_material_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predicted bed layer and register copy
  logic [CODE_W-1:0] bed_model [CELL_COUNT];
  cfg_t bed_cfg = '{bed_last_column: BED_LAST_RST, bed_last_row: BED_LAST_RST,
                    origin_column: '0, origin_row: '0, current_layer: '0};
  // register values the stimulus is currently shaped for
  cfg_t stim_cfg;

  item_t item_backlog [$];
  res_t  awaited_results [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_wait = 0;
  int unsigned hold_left = 0;
  item_t offer;
  item_t seen;
  res_t  want;

  initial begin
    foreach (bed_model[i]) bed_model[i] = '0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    error_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
  endtask

  // expected result of one item, updating the predicted layer
  function automatic res_t rasterize_item(input item_t it);
    res_t r;
    int unsigned col, row, w, h, lo, d, pitch, idx;
    r = '0;
    case (it.kind)
      KIND_CLEAR: begin
        foreach (bed_model[i]) bed_model[i] = '0;
      end
      KIND_DRAW: begin
        col = 32'(bed_cfg.origin_column) + 32'(it.box_column);
        row = 32'(bed_cfg.origin_row) + 32'(it.box_row);
        w = 32'(it.box_width);
        h = 32'(it.box_height);
        lo = 32'(it.box_layer);
        d = 32'(it.box_depth);
        pitch = 32'(bed_cfg.bed_last_column) + 1;
        if (w != 0 && h != 0) begin
          if (col + w - 1 > 32'(bed_cfg.bed_last_column) ||
              row + h - 1 > 32'(bed_cfg.bed_last_row)) begin
            r.status = 1'b1;
          end else if (32'(bed_cfg.current_layer) >= lo &&
                       32'(bed_cfg.current_layer) < lo + d) begin
            for (int unsigned rr = row; rr < row + h; rr++)
              for (int unsigned cc = col; cc < col + w; cc++) begin
                idx = cc + rr * pitch;
                if (idx < CELL_COUNT) bed_model[idx] = it.material;
              end
          end
        end
      end
      KIND_READ: begin
        if (32'(it.cell_address) < CELL_COUNT) r.cell_material = bed_model[it.cell_address];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_item(input logic [1:0] kind, input int unsigned col, row,
                                      layer, w, h, d, mat, addr);
    item_t it;
    it.kind = kind;
    it.box_column = col[COORD_W-1:0];
    it.box_row = row[COORD_W-1:0];
    it.box_layer = layer[COORD_W-1:0];
    it.box_width = w[COORD_W-1:0];
    it.box_height = h[COORD_W-1:0];
    it.box_depth = d[COORD_W-1:0];
    it.material = mat[CODE_W-1:0];
    it.cell_address = addr[IDX_W-1:0];
    return it;
  endfunction

  // mostly boxes that fit and hit the layer, reads inside the bed, some noise
  function automatic item_t random_item();
    item_t it;
    int unsigned pick, cols, rows, lim, w, h, pc, pr, cur, lo, d;
    bit big;
    it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                   $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 15), $urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    cols = 32'(stim_cfg.bed_last_column) + 1;
    rows = 32'(stim_cfg.bed_last_row) + 1;
    if (pick < 2) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 5) begin
      it.kind = KIND_UNUSED;
    end else if (pick < 15) begin
      it.kind = $urandom_range(0, 1) ? KIND_DRAW : KIND_READ;
    end else if (pick < 60) begin
      it.kind = KIND_DRAW;
      big = ($urandom_range(0, 49) == 0);
      lim = (cols < 6) ? cols : 6;
      w = big ? $urandom_range(1, cols) : $urandom_range(1, lim);
      lim = (rows < 6) ? rows : 6;
      h = big ? $urandom_range(1, rows) : $urandom_range(1, lim);
      pc = $urandom_range(0, cols - w);
      pr = $urandom_range(0, rows - h);
      if (pc >= 32'(stim_cfg.origin_column))
        it.box_column = COORD_W'(pc - 32'(stim_cfg.origin_column));
      if (pr >= 32'(stim_cfg.origin_row))
        it.box_row = COORD_W'(pr - 32'(stim_cfg.origin_row));
      // one cell past the bed edge now and then
      if ($urandom_range(0, 7) == 0) w++;
      if ($urandom_range(0, 7) == 0) h++;
      it.box_width = COORD_W'(w);
      it.box_height = COORD_W'(h);
      cur = 32'(stim_cfg.current_layer);
      lo = cur - $urandom_range(0, (cur < 3) ? cur : 3);
      d = cur - lo + $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) d = 65535;
      // depth range that just misses the layer
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) && cur < 65535) lo = cur + 1;
        else d = cur - lo;
      end
      it.box_layer = COORD_W'(lo);
      it.box_depth = COORD_W'(d);
    end else begin
      it.kind = KIND_READ;
      if ($urandom_range(0, 2) != 0)
        it.cell_address = IDX_W'($urandom_range(0, cols - 1) +
                                 $urandom_range(0, rows - 1) * cols);
    end
    return it;
  endfunction

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // write every register; narrow ones carry junk in the unused upper bits
  task automatic apply_settings(input cfg_t s);
    logic [COORD_W-SIDE_W-1:0] junk;
    junk = (COORD_W-SIDE_W)'($urandom_range(0, 1023));
    set_register(REG_UNUSED, COORD_W'($urandom_range(0, 65535)));
    set_register(REG_BED_LAST_COLUMN, {junk, s.bed_last_column});
    junk = (COORD_W-SIDE_W)'($urandom_range(0, 1023));
    set_register(REG_BED_LAST_ROW, {junk, s.bed_last_row});
    set_register(REG_ORIGIN_COLUMN, s.origin_column);
    set_register(REG_ORIGIN_ROW, s.origin_row);
    set_register(REG_CURRENT_LAYER, s.current_layer);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    stim_cfg = s;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (item_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  // item driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_took) begin
      // hold the offered item
    end else if (src_gap > 0) begin
      src_gap--;
      in_valid_i <= 1'b0;
    end else if (item_backlog.size() > 0) begin
      offer = item_backlog.pop_front();
      in_valid_i <= 1'b1;
      kind_i <= offer.kind;
      box_column_i <= offer.box_column;
      box_row_i <= offer.box_row;
      box_layer_i <= offer.box_layer;
      box_width_i <= offer.box_width;
      box_height_i <= offer.box_height;
      box_depth_i <= offer.box_depth;
      material_i <= offer.material;
      cell_address_i <= offer.cell_address;
      if ($urandom_range(0, 19) == 0) src_burst = !src_burst;
      src_gap = src_burst ? 0 : $urandom_range(0, 9);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // result receiver with per-result stalls and one long hold-off
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left = HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (out_took) begin
      if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
      sink_wait = sink_burst ? 0 : $urandom_range(0, 9);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: register copy, prediction, result check, activity count
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BED_LAST_COLUMN: bed_cfg.bed_last_column = cfg_data_i[SIDE_W-1:0];
        REG_BED_LAST_ROW:    bed_cfg.bed_last_row = cfg_data_i[SIDE_W-1:0];
        REG_ORIGIN_COLUMN:   bed_cfg.origin_column = cfg_data_i;
        REG_ORIGIN_ROW:      bed_cfg.origin_row = cfg_data_i;
        REG_CURRENT_LAYER:   bed_cfg.current_layer = cfg_data_i;
        default: ;
      endcase
    end
    if (out_took) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", int'(status_o), 0);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", int'(status_o), int'(want.status));
        if (cell_material_o !== want.cell_material)
          report_mismatch("cell_material", int'(cell_material_o), int'(want.cell_material));
      end
    end
    if (in_took) begin
      seen.kind = kind_i;
      seen.box_column = box_column_i;
      seen.box_row = box_row_i;
      seen.box_layer = box_layer_i;
      seen.box_width = box_width_i;
      seen.box_height = box_height_i;
      seen.box_depth = box_depth_i;
      seen.material = material_i;
      seen.cell_address = cell_address_i;
      awaited_results.push_back(rasterize_item(seen));
    end
    if (!rst_ni || in_took || out_took || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // stimulus phases
  initial begin
    cfg_t s;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, directed corners
    s = '{bed_last_column: 6'd63, bed_last_row: 6'd63, origin_column: 16'd0,
          origin_row: 16'd0, current_layer: 16'd0};
    apply_settings(s);
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4095));
    // whole bed
    item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 0, 64, 64, 1, 15, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4095));
    // empty boxes
    item_backlog.push_back(make_item(KIND_DRAW, 2, 2, 0, 0, 5, 1, 3, 0));
    item_backlog.push_back(make_item(KIND_DRAW, 2, 2, 0, 5, 0, 1, 3, 0));
    // boxes past the bed limits, the last one without wrap
    item_backlog.push_back(make_item(KIND_DRAW, 60, 0, 0, 5, 1, 1, 3, 0));
    item_backlog.push_back(make_item(KIND_DRAW, 0, 63, 0, 1, 2, 1, 3, 0));
    item_backlog.push_back(make_item(KIND_DRAW, 65535, 65535, 0, 65535, 65535, 1, 3, 0));
    // depth ranges missing the layer
    item_backlog.push_back(make_item(KIND_DRAW, 1, 1, 1, 2, 2, 5, 4, 0));
    item_backlog.push_back(make_item(KIND_DRAW, 1, 1, 0, 2, 2, 0, 4, 0));
    item_backlog.push_back(make_item(KIND_DRAW, 1, 1, 65535, 2, 2, 65535, 4, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 65));
    // small box and reads inside and beside it
    item_backlog.push_back(make_item(KIND_DRAW, 5, 7, 0, 3, 2, 1, 9, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 453));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 519));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 456));
    item_backlog.push_back(make_item(KIND_UNUSED, 65535, 65535, 65535, 65535, 65535, 65535,
                                     15, 4095));
    item_backlog.push_back(make_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 453));
    // last cell and material zero
    item_backlog.push_back(make_item(KIND_DRAW, 63, 63, 0, 1, 1, 1, 6, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4095));
    item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 0, 1, 1, 1, 0, 0));
    item_backlog.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    for (int unsigned phase = 1; phase <= PHASES; phase++) begin
      s.bed_last_column = SIDE_W'($urandom_range(0, 63));
      s.bed_last_row = SIDE_W'($urandom_range(0, 63));
      s.origin_column = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 20));
      s.origin_row = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 20));
      s.current_layer = COORD_W'($urandom_range(0, 65535));
      case (phase)
        1: s = '{bed_last_column: 6'd63, bed_last_row: 6'd63, origin_column: 16'd0,
                 origin_row: 16'd0, current_layer: 16'd65535};
        2: s = '{bed_last_column: 6'd0, bed_last_row: 6'd0, origin_column: 16'd0,
                 origin_row: 16'd0, current_layer: 16'd0};
        3: s = '{bed_last_column: 6'd63, bed_last_row: 6'd63, origin_column: 16'd65535,
                 origin_row: 16'd65535, current_layer: 16'd7};
        4: s = '{bed_last_column: 6'd63, bed_last_row: 6'd0, origin_column: 16'd1,
                 origin_row: 16'd0, current_layer: 16'd1};
        default: ;
      endcase
      apply_settings(s);
      // receiver backs off while items keep coming
      if (phase == 5) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) item_backlog.push_back(random_item());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 0, awaited_results.size());
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/vlbr_pkg.sv
sv/vlbr_ram.sv
sv/vlbr_ctrl.sv
sv/voxel_layer_box_rasterizer.sv
sv/vlbr_checker.sv
bench/voxel_layer_box_rasterizer_test.sv
